/* sv/aesc_pkg.sv */
`default_nettype none
package aesc_pkg;

	localparam int KEY_WORDS_DEF   = 4;
	localparam int ROUND_COUNT_DEF = 10;

	// configuration port
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_KEY_A    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_B    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY_C    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_D    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_IV_HIGH  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_IV_LOW   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CHAIN_EN = 3'd6;

	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] XT_POLY   = 8'h1b;
	localparam int         RK_ROW_W  = 8;

	localparam logic [2047:0] FWD_SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

	localparam logic [2047:0] DEC_SBOX = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

	// one round-key word going into the key store
	typedef struct packed {
		logic                we;
		logic [1:0]          bank;
		logic [RK_ROW_W-1:0] row;
		logic [31:0]         data;
	} rk_wr_t;

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? XT_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] sbox_fwd(input logic [7:0] v);
		return FWD_SBOX[(11'd2047 - {v, 3'b000}) -: 8];
	endfunction

	function automatic logic [7:0] sbox_inv(input logic [7:0] v);
		return DEC_SBOX[(11'd2047 - {v, 3'b000}) -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a0, a1, a2, a3, u, v, t;
		a0 = c[31:24];
		a1 = c[23:16];
		a2 = c[15:8];
		a3 = c[7:0];
		if (inv) begin
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			a0 = a0 ^ u;
			a1 = a1 ^ v;
			a2 = a2 ^ u;
			a3 = a3 ^ v;
		end
		t = a0 ^ a1 ^ a2 ^ a3;
		return {a0 ^ t ^ xt(a0 ^ a1), a1 ^ t ^ xt(a1 ^ a2),
			a2 ^ t ^ xt(a2 ^ a3), a3 ^ t ^ xt(a3 ^ a0)};
	endfunction

endpackage
`default_nettype wire

/* sv/aesc_ram.sv */
`default_nettype none
module aesc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/aesc_key_expand.sv */
`default_nettype none
module aesc_key_expand #(
	parameter int KEY_WORDS   = aesc_pkg::KEY_WORDS_DEF,
	parameter int ROUND_COUNT = aesc_pkg::ROUND_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [3:0][63:0]      key,
	output logic                       busy,
	output aesc_pkg::rk_wr_t           wr
);
	localparam int RK_WORDS = 4 * (ROUND_COUNT + 1);
	localparam int IW       = $clog2(RK_WORDS);
	localparam int JW       = $clog2(KEY_WORDS);

	logic                              busy_q;
	logic                              fill_q;
	logic [IW-1:0]                     idx_q;
	logic [JW-1:0]                     j_q;
	logic [1:0]                        col_q;
	logic [aesc_pkg::RK_ROW_W-1:0]     row_q;
	logic [7:0]                        rcon_q;
	logic [KEY_WORDS-1:0][31:0]        win_q;

	logic [2:0]  kx;
	logic [63:0] ksel;
	logic [31:0] kword;
	logic [31:0] t;
	logic [31:0] word;
	logic        rot_step;

	always_comb begin
		kx       = 3'(j_q);
		ksel     = key[kx[2:1]];
		kword    = kx[0] ? ksel[31:0] : ksel[63:32];
		rot_step = !fill_q && (j_q == '0);
		t        = win_q[KEY_WORDS-1];
		if (rot_step) begin
			t = aesc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h000000};
		end else if ((KEY_WORDS > 6) && (32'(j_q) == 4)) begin
			t = aesc_pkg::sub_word(t);
		end
		word = fill_q ? kword : (win_q[0] ^ t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			fill_q <= 1'b1;
			idx_q  <= '0;
			j_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			rcon_q <= aesc_pkg::RCON_INIT;
		end else if (start) begin
			busy_q <= 1'b1;
			fill_q <= 1'b1;
			idx_q  <= '0;
			j_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			rcon_q <= aesc_pkg::RCON_INIT;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			col_q <= col_q + 1'b1;
			if (col_q == 2'd3) begin
				row_q <= row_q + 1'b1;
			end
			if (j_q == JW'(KEY_WORDS - 1)) begin
				j_q    <= '0;
				fill_q <= 1'b0;
			end else begin
				j_q <= j_q + 1'b1;
			end
			if (rot_step) begin
				rcon_q <= aesc_pkg::xt(rcon_q);
			end
			if (idx_q == IW'(RK_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// sliding window of the last KEY_WORDS words, oldest at index 0
	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			win_q <= {word, win_q[KEY_WORDS-1:1]};
		end
	end

	assign busy    = busy_q;
	assign wr.we   = busy_q && !start;
	assign wr.bank = col_q;
	assign wr.row  = row_q;
	assign wr.data = word;
endmodule
`default_nettype wire

/* sv/aesc_round.sv */
`default_nettype none
module aesc_round (
	input  wire logic [127:0] st,
	input  wire logic [127:0] rk,
	input  wire logic         dec,
	input  wire logic         fin,
	output logic      [127:0] nxt
);
	logic [7:0]   b  [16];
	logic [7:0]   sh [16];
	logic [7:0]   sb [16];
	logic [127:0] pre;
	logic [127:0] mixed;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			b[k] = st[127 - 8 * k -: 8];
		end
		// forward: substitute then shift; inverse: unshift then substitute
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (dec) begin
					sh[r + 4 * ((c + r) % 4)] = b[r + 4 * c];
				end else begin
					sh[r + 4 * c] = aesc_pkg::sbox_fwd(b[r + 4 * ((c + r) % 4)]);
				end
			end
		end
		for (int k = 0; k < 16; k++) begin
			sb[k] = dec ? aesc_pkg::sbox_inv(sh[k]) : sh[k];
			pre[127 - 8 * k -: 8] = sb[k];
		end
		if (dec) begin
			pre = pre ^ rk;
		end
		for (int c = 0; c < 4; c++) begin
			mixed[127 - 32 * c -: 32] = aesc_pkg::mix_col(pre[127 - 32 * c -: 32], dec);
		end
		if (dec) begin
			nxt = fin ? pre : mixed;
		end else begin
			nxt = (fin ? pre : mixed) ^ rk;
		end
	end
endmodule
`default_nettype wire

/* sv/aes_block_cipher_cbc.sv */
`default_nettype none
// Channel   Direction  Handshake          Word
// config    in/out     psel/penable/...   64-bit register, byte address 8*index
// in        in         in_valid/in_stall  mode, block_high, block_low, last_block
// out       out        out_valid/out_stall out_high, out_low, out_last
//
// An accepted block runs through the sequencer states in order: the accept edge
// already fetches the whitening key row, ST_INIT does the whitening XOR, ST_ROUND
// runs the rounds one by one through the shared round unit, and ST_FINISH hands
// off. A new block is taken only once the sequencer is back in ST_IDLE.
// Reset starts a round-key expansion of 4*(ROUND_COUNT+1) words (44); every key
// register write starts it again. No block is taken while it runs.
// A result held by out_stall holds the finishing block; the next block can be
// accepted as soon as that result has moved into the output register.
module aes_block_cipher_cbc #(
	parameter int KEY_WORDS   = aesc_pkg::KEY_WORDS_DEF,
	parameter int ROUND_COUNT = aesc_pkg::ROUND_COUNT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [aesc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [aesc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [aesc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic [63:0]                     block_high,
	input  wire logic [63:0]                     block_low,
	input  wire logic                            last_block,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [63:0]                     out_high,
	output logic      [63:0]                     out_low,
	output logic                                 out_last
);
	localparam int AW = $clog2(ROUND_COUNT + 1);
	localparam logic [AW-1:0] RLAST = AW'(ROUND_COUNT);

	// sequencer codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_INIT   = 2'd1;
	localparam logic [1:0] ST_ROUND  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    ka_q;
	logic [AW-1:0]    raddr;
	logic [127:0]     st_q;
	logic [127:0]     blk_q;
	logic             dec_q;
	logic             last_q;
	logic [127:0]     chain_q;
	logic             fresh_q;
	logic [3:0][63:0] key_q;
	logic [127:0]     iv_q;
	logic             cen_q;
	logic             out_valid_q;

	logic             cfg_wr;
	logic [aesc_pkg::REG_IDX_W-1:0] cfg_idx;
	logic             key_wr;
	logic             exp_busy;
	aesc_pkg::rk_wr_t rk_wr;
	logic [127:0]     rk;
	logic [127:0]     rnd_nxt;
	logic [127:0]     chain_val;
	logic [127:0]     init_x;
	logic [127:0]     result;
	logic             fin;
	logic             accept;
	logic             out_free;

	// ---------------- configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];
	assign key_wr  = cfg_wr && ((cfg_idx == aesc_pkg::REG_KEY_A) ||
		(cfg_idx == aesc_pkg::REG_KEY_B) || (cfg_idx == aesc_pkg::REG_KEY_C) ||
		(cfg_idx == aesc_pkg::REG_KEY_D));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
			cen_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				aesc_pkg::REG_KEY_A:    key_q[0]       <= pwdata;
				aesc_pkg::REG_KEY_B:    key_q[1]       <= pwdata;
				aesc_pkg::REG_KEY_C:    key_q[2]       <= pwdata;
				aesc_pkg::REG_KEY_D:    key_q[3]       <= pwdata;
				aesc_pkg::REG_IV_HIGH:  iv_q[127:64]   <= pwdata;
				aesc_pkg::REG_IV_LOW:   iv_q[63:0]     <= pwdata;
				aesc_pkg::REG_CHAIN_EN: cen_q          <= pwdata[0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			aesc_pkg::REG_KEY_A:    prdata = key_q[0];
			aesc_pkg::REG_KEY_B:    prdata = key_q[1];
			aesc_pkg::REG_KEY_C:    prdata = key_q[2];
			aesc_pkg::REG_KEY_D:    prdata = key_q[3];
			aesc_pkg::REG_IV_HIGH:  prdata = iv_q[127:64];
			aesc_pkg::REG_IV_LOW:   prdata = iv_q[63:0];
			aesc_pkg::REG_CHAIN_EN: prdata = {63'd0, cen_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------- round-key store: word 4*r+c lives in bank c, row r
	aesc_key_expand #(
		.KEY_WORDS   (KEY_WORDS),
		.ROUND_COUNT (ROUND_COUNT)
	) u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (key_wr),
		.key    (key_q),
		.busy   (exp_busy),
		.wr     (rk_wr)
	);

	for (genvar c = 0; c < 4; c++) begin : g_bank
		aesc_ram #(
			.WIDTH (32),
			.DEPTH (ROUND_COUNT + 1)
		) u_rk_ram (
			.clk   (clk),
			.we    (rk_wr.we && (rk_wr.bank == 2'(c))),
			.waddr (rk_wr.row[AW-1:0]),
			.wdata (rk_wr.data),
			.raddr (raddr),
			.rdata (rk[127 - 32 * c -: 32])
		);
	end

	// ---------------- sequencer
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || exp_busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign fin       = dec_q ? (ka_q == '0) : (ka_q == RLAST);
	assign chain_val = fresh_q ? iv_q : chain_q;

	// encrypt folds the chain into the plaintext before the whitening key
	assign init_x = (!dec_q && cen_q) ? (blk_q ^ chain_val) : blk_q;
	// decrypt folds the chain into the cipher output
	assign result = (dec_q && cen_q) ? (st_q ^ chain_val) : st_q;

	// issue the key row in the cycle before its use; the RAM read is registered
	always_comb begin
		unique case (state_q)
			ST_IDLE:   raddr = mode ? RLAST : '0;
			ST_INIT:   raddr = dec_q ? (RLAST - 1'b1) : AW'(1);
			ST_ROUND:  raddr = fin ? ka_q : (dec_q ? (ka_q - 1'b1) : (ka_q + 1'b1));
			ST_FINISH: raddr = ka_q;
			default:   raddr = ka_q;
		endcase
	end

	aesc_round u_round (
		.st  (st_q),
		.rk  (rk),
		.dec (dec_q),
		.fin (fin),
		.nxt (rnd_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ka_q        <= '0;
			fresh_q     <= 1'b1;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ka_q <= raddr;
			// load a finished word, or drop the one the receiver took
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (fin) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register frees up
					if (out_free) begin
						fresh_q <= last_q;
						if (!last_q) begin
							chain_q <= dec_q ? blk_q : result;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q  <= {block_high, block_low};
			dec_q  <= mode;
			last_q <= last_block;
		end
		if (state_q == ST_INIT) begin
			st_q <= init_x ^ rk;
		end else if (state_q == ST_ROUND) begin
			st_q <= rnd_nxt;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_high <= result[127:64];
			out_low  <= result[63:0];
			out_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* sv/aesc_checker.sv */
`default_nettype none
module aesc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] out_high,
	input wire logic [63:0] out_low,
	input wire logic        out_last
);
	// a waiting result word holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_high) &&
			$stable(out_low) && $stable(out_last))
		else $error("result word changed while stalled");

	// busy right after a block is taken
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block taken while previous block in flight");

	// still busy while the rounds run
	a_busy_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##3 in_stall)
		else $error("input opened before the rounds finished");

	// an accept with no result word showing is not followed at once by a result word
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result word appeared too early");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");
endmodule

bind aes_block_cipher_cbc aesc_checker u_aesc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_high  (out_high),
	.out_low   (out_low),
	.out_last  (out_last)
);
`default_nettype wire
